@@ sv/i2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, command codes and character constants of the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CountW    = 31;
  localparam int unsigned DigitsMax = 16;
  localparam int unsigned DigIdxW   = $clog2(DigitsMax);

  localparam logic [CmdW-1:0] CmdSignedDec   = 3'd0;
  localparam logic [CmdW-1:0] CmdUnsignedDec = 3'd1;
  localparam logic [CmdW-1:0] CmdHexLower    = 3'd2;
  localparam logic [CmdW-1:0] CmdHexUpper    = 3'd3;
  localparam logic [CmdW-1:0] CmdPointer     = 3'd4;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharX     = 8'h78;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharALow  = 8'h61;
  localparam logic [CharW-1:0] CharAUp   = 8'h41;

  // ceil(2^35 / 10): floor(v * RecipTen / 2^35) == v / 10 for any 32-bit v
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;

  typedef struct packed {
    logic              hex;
    logic              upper;
    logic              ptr;
    logic              neg;
    logic [ValueW-1:0] mag;
  } i2a_item_t;

endpackage

@@ sv/i2a_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_front
// Input stage: accepts requests, drops unused command codes and registers the
// classified item (radix, case, prefix, magnitude) for the queue.
// ----------------------------------------------------------------------------
module i2a_front import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output i2a_item_t         item_o
);

  logic      valid_q, valid_d;
  i2a_item_t item_q, item_d;
  logic      accept;
  logic      cmd_ok;
  logic [31:0] low;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign low          = value_i[31:0];

  always_comb begin
    cmd_ok       = 1'b1;
    item_d.hex   = 1'b0;
    item_d.upper = 1'b0;
    item_d.ptr   = 1'b0;
    item_d.neg   = 1'b0;
    item_d.mag   = {32'd0, low};
    unique case (cmd_i)
      CmdSignedDec: begin
        if (low[31]) begin
          item_d.neg = 1'b1;
          item_d.mag = {32'd0, 32'd0 - low};
        end
      end
      CmdUnsignedDec: begin
      end
      CmdHexLower: begin
        item_d.hex = 1'b1;
      end
      CmdHexUpper: begin
        item_d.hex   = 1'b1;
        item_d.upper = 1'b1;
      end
      CmdPointer: begin
        item_d.hex = 1'b1;
        item_d.ptr = 1'b1;
        item_d.mag = value_i;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (valid_q && !item_ready_i) begin
      valid_d = 1'b1;
    end else begin
      valid_d = accept && cmd_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_ok) begin
      item_q <= item_d;
    end
  end

endmodule

@@ sv/i2a_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_queue
// Two-entry queue between the input stage and the conversion engine.
// ----------------------------------------------------------------------------
module i2a_queue import i2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  i2a_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output i2a_item_t pop_item_o
);

  i2a_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ sv/i2a_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_back
// Conversion engine: splits the magnitude into digits (one hex digit a cycle,
// decimal digits by reciprocal multiply, then remainder), then emits prefix
// and digits most significant first through a registered output slot.
// ----------------------------------------------------------------------------
module i2a_back import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  i2a_item_t         item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  char_out_o,
  output logic              last_o,
  output logic [CountW-1:0] total_count_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StHex  = 3'd3;
  localparam logic [2:0] StPre  = 3'd4;
  localparam logic [2:0] StDig  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic [63:0]        prod_q, prod_d;
  logic [DigIdxW:0]   nd_q, nd_d;
  logic [DigIdxW-1:0] pos_q, pos_d;
  logic               pre_q, pre_d;
  logic               upper_q, ptr_q, neg_q;
  logic [3:0]         dig_q [DigitsMax];
  logic               dig_we;
  logic [3:0]         dig_wdata;

  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               slot_free;
  logic               emit;

  logic [28:0]        quo;
  logic [31:0]        quo_ten;
  logic [31:0]        rem;
  logic [3:0]         dsel;
  logic [CharW-1:0]   dchar;
  logic               load;

  assign item_ready_o  = (state_q == StIdle);
  assign load          = item_valid_i && item_ready_o;
  assign slot_free     = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign char_out_o    = char_q;
  assign last_o        = last_q;
  assign total_count_o = count_q;

  assign quo     = prod_q[63:35];
  assign quo_ten = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem     = val_q[31:0] - quo_ten;
  assign dsel    = dig_q[pos_q];

  always_comb begin
    if (dsel < 4'd10) begin
      dchar = CharZero + {4'd0, dsel};
    end else begin
      dchar = (upper_q ? CharAUp : CharALow) + {4'd0, dsel} - 8'd10;
    end
  end

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    prod_d    = prod_q;
    nd_d      = nd_q;
    pos_d     = pos_q;
    pre_d     = pre_q;
    dig_we    = 1'b0;
    dig_wdata = rem[3:0];
    emit      = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          val_d   = item_i.mag;
          nd_d    = '0;
          pre_d   = 1'b0;
          state_d = item_i.hex ? StHex : StMul;
        end
      end
      StMul: begin
        prod_d  = 64'(val_q[31:0]) * 64'(RecipTen);
        state_d = StDiv;
      end
      StDiv: begin
        dig_we    = 1'b1;
        dig_wdata = rem[3:0];
        nd_d      = nd_q + 1'b1;
        val_d     = {35'd0, quo};
        if (quo == '0) begin
          pos_d   = nd_q[DigIdxW-1:0];
          state_d = neg_q ? StPre : StDig;
        end else begin
          state_d = StMul;
        end
      end
      StHex: begin
        dig_we    = 1'b1;
        dig_wdata = val_q[3:0];
        nd_d      = nd_q + 1'b1;
        val_d     = {4'd0, val_q[ValueW-1:4]};
        if (val_q[ValueW-1:4] == '0) begin
          pos_d   = nd_q[DigIdxW-1:0];
          state_d = ptr_q ? StPre : StDig;
        end
      end
      StPre: begin
        if (slot_free) begin
          emit   = 1'b1;
          last_d = 1'b0;
          if (ptr_q) begin
            char_d = pre_q ? CharX : CharZero;
          end else begin
            char_d = CharMinus;
          end
          pre_d = 1'b1;
          if (!ptr_q || pre_q) begin
            state_d = StDig;
          end
        end
      end
      StDig: begin
        if (slot_free) begin
          emit   = 1'b1;
          char_d = dchar;
          last_d = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prod_q <= prod_d;
    nd_q   <= nd_d;
    pos_q  <= pos_d;
    pre_q  <= pre_d;
    char_q <= char_d;
    last_q <= last_d;
    if (load) begin
      upper_q <= item_i.upper;
      ptr_q   <= item_i.ptr;
      neg_q   <= item_i.neg;
    end
    if (dig_we) begin
      dig_q[nd_q[DigIdxW-1:0]] <= dig_wdata;
    end
  end

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats 32-bit signed/unsigned decimal, 32-bit hex and 64-bit pointers as
// a stream of ASCII characters, most significant digit first.
//
// Input channel (in_valid_i/in_ready_o): one transfer carries cmd_i and
// value_i. Unused command codes are taken and dropped with no output.
// Output channel (out_valid_o/out_ready_i): one transfer per character, with
// last_o on the final character of a request and total_count_o giving the
// saturating number of characters sent since reset, this one included.
// A request passes the input register and then the queue; conversion then takes
// a reciprocal multiply and a remainder step per decimal digit, or a single step
// per hex digit; characters follow at one per cycle while the receiver is ready.
// The engine takes a new request only once it has put out the last character
// of the previous one.
// The input register and two-entry queue keep taking requests while the
// engine works or the receiver stalls; a stalled receiver holds the engine.
// Reset clears all control state and the character count.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  char_out_o,
  output logic              last_o,
  output logic [CountW-1:0] total_count_o
);

  logic      f_valid, f_ready;
  i2a_item_t f_item;
  logic      b_valid, b_ready;
  i2a_item_t b_item;

  i2a_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  i2a_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  i2a_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (b_valid),
    .item_ready_o  (b_ready),
    .item_i        (b_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_out_o    (char_out_o),
    .last_o        (last_o),
    .total_count_o (total_count_o)
  );

endmodule

@@ tb/sv/ascii_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_stream_checker
// Watches both channels of the integer to ASCII formatter. Each request taken
// on the input channel is formatted here into the characters it should give,
// with the last marker and the running character count. Every character
// transfer on the output channel is compared field by field against the
// oldest character still owed. The failure count and the number of
// characters still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module ascii_stream_checker import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CharW-1:0]  char_i,
  input  logic              last_i,
  input  logic [CountW-1:0] total_count_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              last;
    logic [CountW-1:0] count;
  } char_beat_t;

  char_beat_t        expected_chars[$];
  logic [CountW-1:0] chars_sent;
  int                fail_count;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input bit upper);
    if (d < 4'd10) begin
      return CharZero + CharW'(d);
    end
    return (upper ? CharAUp : CharALow) + CharW'(d - 4'd10);
  endfunction

  function automatic void format_request(input logic [CmdW-1:0] cmd,
                                         input logic [ValueW-1:0] value);
    logic [CharW-1:0]  text[$];
    logic [CharW-1:0]  digits[$];
    logic [ValueW-1:0] mag;
    logic [31:0]       neg_low;
    logic [ValueW-1:0] radix;
    bit                upper;
    char_beat_t        beat;
    upper = 1'b0;
    radix = 64'd16;
    mag   = {32'd0, value[31:0]};
    case (cmd)
      CmdSignedDec: begin
        radix = 64'd10;
        if (value[31]) begin
          text.push_back(CharMinus);
          neg_low = ~value[31:0] + 32'd1;
          mag     = {32'd0, neg_low};
        end
      end
      CmdUnsignedDec: radix = 64'd10;
      CmdHexLower: ;
      CmdHexUpper: upper = 1'b1;
      CmdPointer: begin
        text.push_back(CharZero);
        text.push_back(CharX);
        mag = value;
      end
      default: return;
    endcase
    do begin
      digits.push_front(digit_char(4'(mag % radix), upper));
      mag = mag / radix;
    end while (mag != 64'd0);
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      if (chars_sent != {CountW{1'b1}}) chars_sent = chars_sent + 1'b1;
      beat.ch    = text[i];
      beat.last  = (i == text.size() - 1);
      beat.count = chars_sent;
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      chars_sent = '0;
      fail_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) format_request(cmd_i, value_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: character 0x%02h with nothing expected", $time, char_i);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_i !== want.ch) begin
            $display("%0t: char_out expected 0x%02h actual 0x%02h", $time, want.ch, char_i);
            fail_count++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_i);
            fail_count++;
          end
          if (total_count_i !== want.count) begin
            $display("%0t: total_count expected %0d actual %0d", $time, want.count,
                     total_count_i);
            fail_count++;
          end
        end
      end
      errors_o  <= fail_count;
      pending_o <= expected_chars.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives conversion requests into the integer to ASCII formatter: a directed
// set covering every mode, the field extremes, the most negative value, a
// zero pointer and the unused command codes, then random requests with
// bursts of idling on both channels and a final stretch without any. The
// checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module testbench;
  import i2a_pkg::*;

  localparam logic [CmdW-1:0] CmdSpare0 = 3'd5;
  localparam logic [CmdW-1:0] CmdSpare1 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare2 = 3'd7;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 64;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CmdW-1:0]   cmd = '0;
  logic [ValueW-1:0] value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CharW-1:0]  char_out;
  logic              last;
  logic [CountW-1:0] total_count;
  int                errors;
  int                pending;
  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;
  int                rx_wait = 0;
  int                quiet_cycles = 0;

  always #10 clk = ~clk;

  integer_to_ascii_formatter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .char_out_o    (char_out),
    .last_o        (last),
    .total_count_o (total_count)
  );

  ascii_stream_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .char_i        (char_out),
    .last_i        (last),
    .total_count_i (total_count),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // receiver: hold ready low in random bursts while rx_idle is set
  always @(posedge clk) begin
    if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end else if (rx_idle && out_ready && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_wait   <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [CmdW-1:0] c, input logic [ValueW-1:0] v);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return ValueW'($urandom_range(0, 20));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: return {$urandom, 32'h8000_0000 | 32'($urandom_range(0, 15))};
      4: return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 15))};
      default: return ValueW'(10 ** $urandom_range(0, 9)) - ValueW'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_random_batch(input int n);
    int               sent;
    logic [CmdW-1:0]  c;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 19) == 0) begin
        c = CmdW'($urandom_range(CmdSpare0, CmdSpare2));
      end else begin
        c = CmdW'($urandom_range(CmdSignedDec, CmdPointer));
        sent++;
      end
      send_request(c, random_value());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(CmdSignedDec, 64'd0);
    send_request(CmdSignedDec, 64'd1);
    send_request(CmdSignedDec, 64'h0000_0000_FFFF_FFFF);
    send_request(CmdSignedDec, 64'h0000_0000_7FFF_FFFF);
    send_request(CmdSignedDec, 64'h0000_0000_8000_0000);
    send_request(CmdSignedDec, 64'hFFFF_FFFF_FFFE_1DC0);
    send_request(CmdUnsignedDec, 64'd0);
    send_request(CmdUnsignedDec, 64'h0000_0000_FFFF_FFFF);
    send_request(CmdUnsignedDec, 64'hA5A5_A5A5_3B9A_CA00);
    send_request(CmdHexLower, 64'd0);
    send_request(CmdHexLower, 64'h0000_0000_FFFF_FFFF);
    send_request(CmdHexLower, 64'h1234_5678_DEAD_BEEF);
    send_request(CmdHexUpper, 64'd0);
    send_request(CmdHexUpper, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CmdHexUpper, 64'h0000_0000_0ABC_DEF9);
    send_request(CmdPointer, 64'd0);
    send_request(CmdPointer, 64'd1);
    send_request(CmdPointer, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CmdPointer, 64'h8000_0000_0000_0000);
    send_request(CmdSpare0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CmdSpare1, 64'd0);
    send_request(CmdSpare2, 64'h0000_0000_8000_0000);
    wait_drained();

    send_random_batch(200);
    wait_drained();
    send_random_batch(60);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random_batch(60);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
